// ===== design/evu_pkg.sv =====
// Shared widths, codes and transaction types for the voxel distance update block.
package evu_pkg;

    localparam int DIST_WIDTH       = 24;
    localparam int DIST_FRAC_BITS   = 8;
    localparam int WEIGHT_WIDTH     = 16;
    localparam int WEIGHT_FRAC_BITS = 14;
    localparam int NUM_LANES        = 6;
    localparam int SUM_GROW         = 3;
    localparam int LANE_STAGES      = 3;

    localparam int WD_W      = WEIGHT_WIDTH + DIST_WIDTH;
    localparam int DSQ_W     = 2 * DIST_WIDTH;
    localparam int WDD_W     = WEIGHT_WIDTH + DSQ_W;
    localparam int A_W       = WEIGHT_WIDTH + SUM_GROW;
    localparam int B_W       = WD_W + SUM_GROW;
    localparam int C_W       = WDD_W + SUM_GROW;
    localparam int P_W       = A_W + C_W;
    localparam int POS_SHIFT = WEIGHT_FRAC_BITS + 2 * DIST_FRAC_BITS;
    localparam int Q_W       = A_W + POS_SHIFT;
    localparam int R_W       = (Q_W + 1) / 2;
    localparam int DL_W      = Q_W + 2;
    localparam int NUM_W     = B_W + 1;
    localparam int CH_W      = (C_W + 2) / 3;
    localparam int CE_W      = 3 * CH_W;
    localparam int BL_W      = (B_W + 1) / 2;
    localparam int BH_W      = B_W - BL_W;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_Z = 2'd2;

    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_X_RESET = 16'd16384;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_Y_RESET = 16'd16384;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_Z_RESET = 16'd11378;

    typedef logic [DIST_WIDTH-1:0]   dist_t;
    typedef logic [WEIGHT_WIDTH-1:0] weight_t;

    typedef enum logic [2:0] {
        ST_TWO_ROOTS   = 3'd0,
        ST_DOUBLE_ROOT = 3'd1,
        ST_NO_ROOT     = 3'd2,
        ST_NO_KNOWN    = 3'd3,
        ST_SATURATED   = 3'd4
    } status_t;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        logic [Q_W-1:0] q;
        status_t        st;
        logic           solved;
    } root_job_t;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic [B_W-1:0] b;
        logic [R_W-1:0] root;
        status_t        st;
        logic           solved;
    } root_res_t;

    typedef struct packed {
        logic [A_W-1:0]   a;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] quo;
        status_t          st;
        logic             solved;
    } div_job_t;

    typedef struct packed {
        dist_t   dist_code;
        status_t st;
    } result_t;

endpackage

// ===== design/evu_lane.sv =====
// One neighbour lane: weight, weighted distance and weighted squared distance.
module evu_lane (
    input  logic                             clk,
    input  logic                             en,
    input  evu_pkg::weight_t                 weight,
    input  evu_pkg::dist_t                   dist_in,
    input  logic                             known,
    output evu_pkg::weight_t                 wm,
    output logic [evu_pkg::WD_W-1:0]         wd,
    output logic [evu_pkg::WDD_W-1:0]        wdd,
    output logic                             known_out
);

    evu_pkg::weight_t                 wm1_reg, wm1_next, wm2_reg, wm3_reg;
    logic [evu_pkg::WD_W-1:0]         wd1_reg, wd1_next, wd2_reg, wd3_reg;
    logic [evu_pkg::DSQ_W-1:0]        dsq1_reg, dsq1_next;
    logic [evu_pkg::WD_W-1:0]         plo2_reg, plo2_next, phi2_reg, phi2_next;
    logic [evu_pkg::WDD_W-1:0]        wdd3_reg, wdd3_next;
    logic                             k1_reg, k2_reg, k3_reg;

    assign wm1_next  = known ? weight : '0;
    assign wd1_next  = evu_pkg::WD_W'(wm1_next) * evu_pkg::WD_W'(dist_in);
    assign dsq1_next = evu_pkg::DSQ_W'(dist_in) * evu_pkg::DSQ_W'(dist_in);

    // split the square so each product stays 16 x 24
    assign plo2_next = evu_pkg::WD_W'(wm1_reg)
                     * evu_pkg::WD_W'(dsq1_reg[evu_pkg::DIST_WIDTH-1:0]);
    assign phi2_next = evu_pkg::WD_W'(wm1_reg)
                     * evu_pkg::WD_W'(dsq1_reg[evu_pkg::DSQ_W-1:evu_pkg::DIST_WIDTH]);

    assign wdd3_next = evu_pkg::WDD_W'(plo2_reg)
                     + (evu_pkg::WDD_W'(phi2_reg) << evu_pkg::DIST_WIDTH);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wm1_reg  <= wm1_next;
            wd1_reg  <= wd1_next;
            dsq1_reg <= dsq1_next;
            k1_reg   <= known;
            wm2_reg  <= wm1_reg;
            wd2_reg  <= wd1_reg;
            plo2_reg <= plo2_next;
            phi2_reg <= phi2_next;
            k2_reg   <= k1_reg;
            wm3_reg  <= wm2_reg;
            wd3_reg  <= wd2_reg;
            wdd3_reg <= wdd3_next;
            k3_reg   <= k2_reg;
        end
    end

    assign wm        = wm3_reg;
    assign wd        = wd3_reg;
    assign wdd       = wdd3_reg;
    assign known_out = k3_reg;

endmodule

// ===== design/evu_merge.sv =====
// Merge of lane sums into the quarter discriminant and early status.
module evu_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        valid_in,
    input  evu_pkg::weight_t            wm [evu_pkg::NUM_LANES],
    input  logic [evu_pkg::WD_W-1:0]    wd [evu_pkg::NUM_LANES],
    input  logic [evu_pkg::WDD_W-1:0]   wdd [evu_pkg::NUM_LANES],
    input  logic                        known [evu_pkg::NUM_LANES],
    output logic                        valid_out,
    output evu_pkg::root_job_t          job
);

    logic [evu_pkg::A_W-1:0]  a0_next, a0_reg, a1_reg, a2_reg, a3_reg;
    logic [evu_pkg::B_W-1:0]  b0_next, b0_reg, b1_reg, b2_reg, b3_reg;
    logic [evu_pkg::C_W-1:0]  c0_next, c0_reg;
    logic                     any0_next, any0_reg, any1_reg, any2_reg, any3_reg;
    logic [evu_pkg::CE_W-1:0] c_ext;
    logic [evu_pkg::A_W+evu_pkg::CH_W-1:0] pp_reg [3];
    logic [2*evu_pkg::BL_W-1:0]            ll_reg;
    logic [evu_pkg::BL_W+evu_pkg::BH_W-1:0] lh_reg;
    logic [2*evu_pkg::BH_W-1:0]            hh_reg;
    logic [evu_pkg::P_W-1:0]  ac2_next, ac2_reg, bb2_next, bb2_reg, n3_reg;
    logic [evu_pkg::P_W-1:0]  pos, diff;
    evu_pkg::root_job_t       job_next, job_reg;
    logic [4:0]               vld_reg;

    always_comb
    begin
        a0_next   = '0;
        b0_next   = '0;
        c0_next   = '0;
        any0_next = 1'b0;
        for (int i = 0; i < evu_pkg::NUM_LANES; i++)
        begin
            a0_next   = a0_next + evu_pkg::A_W'(wm[i]);
            b0_next   = b0_next + evu_pkg::B_W'(wd[i]);
            c0_next   = c0_next + evu_pkg::C_W'(wdd[i]);
            any0_next = any0_next | known[i];
        end
    end

    assign c_ext = evu_pkg::CE_W'(c0_reg);

    // A*C and B*B rebuilt from registered partial products
    assign ac2_next = evu_pkg::P_W'(pp_reg[0])
                    + (evu_pkg::P_W'(pp_reg[1]) << evu_pkg::CH_W)
                    + (evu_pkg::P_W'(pp_reg[2]) << (2 * evu_pkg::CH_W));
    assign bb2_next = evu_pkg::P_W'(ll_reg)
                    + (evu_pkg::P_W'(lh_reg) << (evu_pkg::BL_W + 1))
                    + (evu_pkg::P_W'(hh_reg) << (2 * evu_pkg::BL_W));

    assign pos  = evu_pkg::P_W'(a3_reg) << evu_pkg::POS_SHIFT;
    assign diff = pos - n3_reg;

    always_comb
    begin
        job_next.a      = a3_reg;
        job_next.b      = b3_reg;
        job_next.q      = diff[evu_pkg::Q_W-1:0];
        job_next.solved = 1'b0;
        job_next.st     = evu_pkg::ST_NO_ROOT;
        if (!any3_reg)
        begin
            job_next.st = evu_pkg::ST_NO_KNOWN;
        end
        else if (a3_reg == '0 || n3_reg > pos)
        begin
            job_next.st = evu_pkg::ST_NO_ROOT;
        end
        else
        begin
            job_next.solved = 1'b1;
            job_next.st     = (diff == '0) ? evu_pkg::ST_DOUBLE_ROOT : evu_pkg::ST_TWO_ROOTS;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg   <= a0_next;
            b0_reg   <= b0_next;
            c0_reg   <= c0_next;
            any0_reg <= any0_next;
            for (int k = 0; k < 3; k++)
            begin
                pp_reg[k] <= (evu_pkg::A_W + evu_pkg::CH_W)'(a0_reg)
                           * (evu_pkg::A_W + evu_pkg::CH_W)'(c_ext[k*evu_pkg::CH_W +: evu_pkg::CH_W]);
            end
            ll_reg   <= (2*evu_pkg::BL_W)'(b0_reg[evu_pkg::BL_W-1:0])
                      * (2*evu_pkg::BL_W)'(b0_reg[evu_pkg::BL_W-1:0]);
            lh_reg   <= (evu_pkg::BL_W+evu_pkg::BH_W)'(b0_reg[evu_pkg::BL_W-1:0])
                      * (evu_pkg::BL_W+evu_pkg::BH_W)'(b0_reg[evu_pkg::B_W-1:evu_pkg::BL_W]);
            hh_reg   <= (2*evu_pkg::BH_W)'(b0_reg[evu_pkg::B_W-1:evu_pkg::BL_W])
                      * (2*evu_pkg::BH_W)'(b0_reg[evu_pkg::B_W-1:evu_pkg::BL_W]);
            a1_reg   <= a0_reg;
            b1_reg   <= b0_reg;
            any1_reg <= any0_reg;
            ac2_reg  <= ac2_next;
            bb2_reg  <= bb2_next;
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            any2_reg <= any1_reg;
            n3_reg   <= ac2_reg - bb2_reg;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
            any3_reg <= any2_reg;
            job_reg  <= job_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[3:0], valid_in};
        end
    end

    assign valid_out = vld_reg[4];
    assign job       = job_reg;

endmodule

// ===== design/evu_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module evu_sqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  evu_pkg::root_job_t job,
    output logic               valid_out,
    output evu_pkg::root_res_t res
);

    logic [evu_pkg::Q_W-1:0] rem_reg [evu_pkg::R_W];
    evu_pkg::root_res_t      res_reg [evu_pkg::R_W];
    logic                    vld_reg [evu_pkg::R_W];

    for (genvar k = 0; k < evu_pkg::R_W; k++)
    begin : g_stage
        localparam int BIT = evu_pkg::R_W - 1 - k;
        logic [evu_pkg::Q_W-1:0]  rem_in, rem_next;
        evu_pkg::root_res_t       res_in, res_next;
        logic                     vld_in;
        logic [evu_pkg::DL_W-1:0] delta, diff;
        logic                     take;

        if (k == 0)
        begin : g_first
            assign rem_in        = job.q;
            assign res_in.a      = job.a;
            assign res_in.b      = job.b;
            assign res_in.root   = '0;
            assign res_in.st     = job.st;
            assign res_in.solved = job.solved;
            assign vld_in        = valid_in;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign delta = (evu_pkg::DL_W'(res_in.root) << (BIT + 1))
                     | (evu_pkg::DL_W'(1) << (2 * BIT));
        assign diff  = {2'b00, rem_in} - delta;
        assign take  = {2'b00, rem_in} >= delta;

        always_comb
        begin
            res_next = res_in;
            rem_next = rem_in;
            if (take)
            begin
                rem_next      = diff[evu_pkg::Q_W-1:0];
                res_next.root = res_in.root | (evu_pkg::R_W'(1) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign valid_out = vld_reg[evu_pkg::R_W-1];
    assign res       = res_reg[evu_pkg::R_W-1];

endmodule

// ===== design/evu_div.sv =====
// Pipelined restoring divide (B + root) / A and final saturation.
module evu_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid_in,
    input  evu_pkg::root_res_t res,
    output logic               valid_out,
    output evu_pkg::result_t   result
);

    evu_pkg::div_job_t       pre_reg, pre_next;
    logic                    pre_vld_reg;
    logic [evu_pkg::A_W-1:0] rem_reg [evu_pkg::NUM_W];
    evu_pkg::div_job_t       job_reg [evu_pkg::NUM_W];
    logic                    vld_reg [evu_pkg::NUM_W];
    evu_pkg::div_job_t       last;
    evu_pkg::result_t        out_next, out_reg;
    logic                    out_vld_reg;

    always_comb
    begin
        pre_next.a      = res.a;
        pre_next.num    = evu_pkg::NUM_W'(res.b) + evu_pkg::NUM_W'(res.root);
        pre_next.quo    = '0;
        pre_next.st     = res.st;
        pre_next.solved = res.solved;
    end

    for (genvar k = 0; k < evu_pkg::NUM_W; k++)
    begin : g_stage
        localparam int BIT = evu_pkg::NUM_W - 1 - k;
        logic [evu_pkg::A_W-1:0] rem_in, rem_next;
        evu_pkg::div_job_t       job_in, job_next;
        logic                    vld_in;
        logic [evu_pkg::A_W:0]   part, diff;
        logic                    take;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign job_in = pre_reg;
            assign vld_in = pre_vld_reg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign job_in = job_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign part = {rem_in, job_in.num[BIT]};
        assign diff = part - {1'b0, job_in.a};
        assign take = part >= {1'b0, job_in.a};

        always_comb
        begin
            job_next = job_in;
            rem_next = part[evu_pkg::A_W-1:0];
            if (take)
            begin
                rem_next     = diff[evu_pkg::A_W-1:0];
                job_next.quo = job_in.quo | (evu_pkg::NUM_W'(1) << BIT);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                job_reg[k] <= job_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end
    end

    assign last = job_reg[evu_pkg::NUM_W-1];

    always_comb
    begin
        out_next.dist_code = '0;
        out_next.st        = last.st;
        if (last.solved)
        begin
            if (last.quo[evu_pkg::NUM_W-1:evu_pkg::DIST_WIDTH] != '0)
            begin
                out_next.dist_code = '1;
                out_next.st        = evu_pkg::ST_SATURATED;
            end
            else
            begin
                out_next.dist_code = last.quo[evu_pkg::DIST_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pre_reg <= pre_next;
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            pre_vld_reg <= valid_in;
            out_vld_reg <= vld_reg[evu_pkg::NUM_W-1];
        end
    end

    assign valid_out = out_vld_reg;
    assign result    = out_reg;

endmodule

// ===== design/eikonal_voxel_distance_update.sv =====
// An accepted input transaction passes through the lanes, merge, square root and divide (with its
// operand and result stages) and then the output register before it reaches out_valid.
// Throughput: one transaction per cycle unless in_stall; root and divide are fully pipelined.
// A skid register behind the output holds one result while out_stall is high.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the default weights.
module eikonal_voxel_distance_update (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [23:0]                       dist_x_minus,
    input  logic [23:0]                       dist_x_plus,
    input  logic [23:0]                       dist_y_minus,
    input  logic [23:0]                       dist_y_plus,
    input  logic [23:0]                       dist_z_minus,
    input  logic [23:0]                       dist_z_plus,
    input  logic                              known_x_minus,
    input  logic                              known_x_plus,
    input  logic                              known_y_minus,
    input  logic                              known_y_plus,
    input  logic                              known_z_minus,
    input  logic                              known_z_plus,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [23:0]                       new_distance,
    output logic [2:0]                        solve_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [evu_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);

    evu_pkg::weight_t             weight_x_reg, weight_y_reg, weight_z_reg;
    evu_pkg::dist_t               dist_arr [evu_pkg::NUM_LANES];
    logic                         known_arr [evu_pkg::NUM_LANES];
    evu_pkg::weight_t             lane_w [evu_pkg::NUM_LANES];
    evu_pkg::weight_t             lane_wm [evu_pkg::NUM_LANES];
    logic [evu_pkg::WD_W-1:0]     lane_wd [evu_pkg::NUM_LANES];
    logic [evu_pkg::WDD_W-1:0]    lane_wdd [evu_pkg::NUM_LANES];
    logic                         lane_known [evu_pkg::NUM_LANES];
    logic [evu_pkg::LANE_STAGES-1:0] lane_vld_reg;
    logic                         en;
    logic                         merge_vld, sqrt_vld, div_vld;
    evu_pkg::root_job_t           merge_job;
    evu_pkg::root_res_t           sqrt_res;
    evu_pkg::result_t             div_res;
    logic                         leave, take_out;
    logic                         out_valid_reg, out_valid_next;
    logic                         skid_full_reg, skid_full_next;
    evu_pkg::result_t             out_reg, out_next, skid_reg, skid_next;

    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_x_reg <= evu_pkg::WEIGHT_X_RESET;
            weight_y_reg <= evu_pkg::WEIGHT_Y_RESET;
            weight_z_reg <= evu_pkg::WEIGHT_Z_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                evu_pkg::CFG_WEIGHT_X: weight_x_reg <= cfg_data;
                evu_pkg::CFG_WEIGHT_Y: weight_y_reg <= cfg_data;
                evu_pkg::CFG_WEIGHT_Z: weight_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign dist_arr[0]  = dist_x_minus;
    assign dist_arr[1]  = dist_x_plus;
    assign dist_arr[2]  = dist_y_minus;
    assign dist_arr[3]  = dist_y_plus;
    assign dist_arr[4]  = dist_z_minus;
    assign dist_arr[5]  = dist_z_plus;
    assign known_arr[0] = known_x_minus;
    assign known_arr[1] = known_x_plus;
    assign known_arr[2] = known_y_minus;
    assign known_arr[3] = known_y_plus;
    assign known_arr[4] = known_z_minus;
    assign known_arr[5] = known_z_plus;

    for (genvar l = 0; l < evu_pkg::NUM_LANES; l++)
    begin : g_lane
        if (l < 2)
        begin : g_x
            assign lane_w[l] = weight_x_reg;
        end
        else if (l < 4)
        begin : g_y
            assign lane_w[l] = weight_y_reg;
        end
        else
        begin : g_z
            assign lane_w[l] = weight_z_reg;
        end

        evu_lane u_lane (
            .clk       (clk),
            .en        (en),
            .weight    (lane_w[l]),
            .dist_in   (dist_arr[l]),
            .known     (known_arr[l]),
            .wm        (lane_wm[l]),
            .wd        (lane_wd[l]),
            .wdd       (lane_wdd[l]),
            .known_out (lane_known[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_vld_reg <= '0;
        end
        else if (en)
        begin
            lane_vld_reg <= {lane_vld_reg[evu_pkg::LANE_STAGES-2:0], in_valid};
        end
    end

    evu_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (lane_vld_reg[evu_pkg::LANE_STAGES-1]),
        .wm        (lane_wm),
        .wd        (lane_wd),
        .wdd       (lane_wdd),
        .known     (lane_known),
        .valid_out (merge_vld),
        .job       (merge_job)
    );

    evu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (merge_vld),
        .job       (merge_job),
        .valid_out (sqrt_vld),
        .res       (sqrt_res)
    );

    evu_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (sqrt_vld),
        .res       (sqrt_res),
        .valid_out (div_vld),
        .result    (div_res)
    );

    // output register plus one skid entry; freeze the pipeline while the skid is full
    assign leave    = div_vld && en;
    assign take_out = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        skid_full_next = skid_full_reg;
        skid_next      = skid_reg;
        if (take_out)
        begin
            if (skid_full_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = skid_reg;
                skid_full_next = 1'b0;
            end
            else
            begin
                out_valid_next = leave;
                out_next       = div_res;
            end
        end
        else if (leave)
        begin
            skid_next      = div_res;
            skid_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign new_distance = out_reg.dist_code;
    assign solve_status = out_reg.st;

endmodule

// ===== design/evu_checker.sv =====
// Port-level checks for the voxel distance update block, bound to the top level.
module evu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [23:0] new_distance,
    input logic [2:0]  solve_status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_distance) && $stable(solve_status))
        else $error("result changed while stalled");

    a_unsolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (solve_status == evu_pkg::ST_NO_ROOT
                      || solve_status == evu_pkg::ST_NO_KNOWN) |-> new_distance == '0)
        else $error("unsolved result with nonzero distance");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && solve_status == evu_pkg::ST_SATURATED |-> new_distance == '1)
        else $error("saturated result below maximum");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a blocked output");

    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind eikonal_voxel_distance_update evu_checker u_evu_checker (.*);

// ===== dv/eikonal_voxel_distance_update_tb.sv =====
// Self-checking testbench for the voxel distance update block.
`timescale 1ns / 1ps

module eikonal_voxel_distance_update_tb;

    typedef struct {
        evu_pkg::dist_t d [6];
        logic [5:0]     k;
    } voxel_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [23:0]                   dist_x_minus, dist_x_plus, dist_y_minus;
    logic [23:0]                   dist_y_plus, dist_z_minus, dist_z_plus;
    logic                          known_x_minus, known_x_plus, known_y_minus;
    logic                          known_y_plus, known_z_minus, known_z_plus;
    logic                          out_valid;
    logic                          out_stall;
    logic [23:0]                   new_distance;
    logic [2:0]                    solve_status;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [evu_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                   cfg_data;

    evu_pkg::weight_t wx, wy, wz;
    evu_pkg::result_t expected_results [$];
    int      mismatches;
    int      rx_wait;
    int      rx_hold;
    bit      tx_quiet;
    bit      rx_quiet;

    eikonal_voxel_distance_update uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dist_x_minus  (dist_x_minus),
        .dist_x_plus   (dist_x_plus),
        .dist_y_minus  (dist_y_minus),
        .dist_y_plus   (dist_y_plus),
        .dist_z_minus  (dist_z_minus),
        .dist_z_plus   (dist_z_plus),
        .known_x_minus (known_x_minus),
        .known_x_plus  (known_x_plus),
        .known_y_minus (known_y_minus),
        .known_y_plus  (known_y_plus),
        .known_z_minus (known_z_minus),
        .known_z_plus  (known_z_plus),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .new_distance  (new_distance),
        .solve_status  (solve_status),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Exact arrival-time solve for one voxel under the current weights.
    function automatic evu_pkg::result_t solve_voxel(voxel_t v);
        logic [127:0]     pos, negsum, q, root, cand, diff;
        logic [63:0]      w [6];
        logic [63:0]      asum, bsum, t;
        evu_pkg::result_t r;
        int               i, j, b;
        asum = 0;
        bsum = 0;
        for (i = 0; i < 6; i++)
        begin
            w[i] = (i < 2) ? 64'(wx) : (i < 4) ? 64'(wy) : 64'(wz);
            if (v.k[i])
            begin
                asum += w[i];
                bsum += w[i] * 64'(v.d[i]);
            end
        end
        r.dist_code = '0;
        if (v.k == 6'b0)
            r.st = evu_pkg::ST_NO_KNOWN;
        else if (asum == 0)
            r.st = evu_pkg::ST_NO_ROOT;
        else
        begin
            pos = 128'(asum) << evu_pkg::POS_SHIFT;
            negsum = '0;
            for (i = 0; i < 6; i++)
                for (j = i + 1; j < 6; j++)
                    if (v.k[i] && v.k[j])
                    begin
                        diff = (v.d[i] > v.d[j]) ? 128'(v.d[i] - v.d[j])
                                                 : 128'(v.d[j] - v.d[i]);
                        negsum += 128'(w[i] * w[j]) * diff * diff;
                    end
            if (negsum > pos)
                r.st = evu_pkg::ST_NO_ROOT;
            else
            begin
                q = pos - negsum;
                root = '0;
                for (b = 34; b >= 0; b--)
                begin
                    cand = root | (128'd1 << b);
                    if (cand * cand <= q)
                        root = cand;
                end
                t = (bsum + 64'(root)) / asum;
                r.st = (q == 0) ? evu_pkg::ST_DOUBLE_ROOT : evu_pkg::ST_TWO_ROOTS;
                if (t > 64'hFFFFFF)
                begin
                    t = 64'hFFFFFF;
                    r.st = evu_pkg::ST_SATURATED;
                end
                r.dist_code = t[23:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Result checker: compare each accepted transaction with the oldest expectation.
    always @(posedge clk)
    begin
        evu_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", new_distance, 0);
            else
            begin
                want = expected_results.pop_front();
                if (new_distance !== want.dist_code)
                    report_mismatch("new_distance", new_distance, want.dist_code);
                if (solve_status !== want.st)
                    report_mismatch("solve_status", solve_status, want.st);
            end
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 8);
        end
    end

    // Receiver stall: long hold first, then per-result random wait.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall = 1'b1;
                rx_hold--;
            end
            else if (rx_wait > 0)
            begin
                out_stall = 1'b1;
                rx_wait--;
            end
            else
                out_stall = 1'b0;
        end
    end

    task automatic send_voxel(voxel_t v);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        dist_x_minus  = v.d[0];
        dist_x_plus   = v.d[1];
        dist_y_minus  = v.d[2];
        dist_y_plus   = v.d[3];
        dist_z_minus  = v.d[4];
        dist_z_plus   = v.d[5];
        known_x_minus = v.k[0];
        known_x_plus  = v.k[1];
        known_y_minus = v.k[2];
        known_y_plus  = v.k[3];
        known_z_minus = v.k[4];
        known_z_plus  = v.k[5];
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_results = {expected_results, solve_voxel(v)};
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_weight(logic [evu_pkg::CFG_IDX_W-1:0] idx, evu_pkg::weight_t value);
        drain();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            evu_pkg::CFG_WEIGHT_X: wx = value;
            evu_pkg::CFG_WEIGHT_Y: wy = value;
            evu_pkg::CFG_WEIGHT_Z: wz = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic voxel_t make_voxel(evu_pkg::dist_t d0, evu_pkg::dist_t d1,
                                          logic [5:0] k);
        voxel_t v;
        int     i;
        for (i = 0; i < 6; i++)
            v.d[i] = (i == 0) ? d0 : d1;
        v.k = k;
        return v;
    endfunction

    // Mostly neighbors clustered around a front value so real roots appear.
    function automatic voxel_t rand_voxel();
        voxel_t v;
        int     i;
        int     mode;
        longint base, spread, val;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 20);
        spread = 64'd1 << $urandom_range(0, 12);
        for (i = 0; i < 6; i++)
        begin
            if (mode < 8)
            begin
                val = base + $urandom_range(0, spread);
                v.d[i] = (val > 24'hFFFFFF) ? 24'hFFFFFF : val[23:0];
            end
            else
                v.d[i] = 24'($urandom_range(0, 24'hFFFFFF));
        end
        v.k = 6'($urandom_range(0, 63));
        return v;
    endfunction

    task automatic set_weights(evu_pkg::weight_t x, evu_pkg::weight_t y, evu_pkg::weight_t z);
        write_weight(evu_pkg::CFG_WEIGHT_X, x);
        write_weight(evu_pkg::CFG_WEIGHT_Y, y);
        write_weight(evu_pkg::CFG_WEIGHT_Z, z);
    endtask

    task automatic test_directed;
        int i;
        send_voxel(make_voxel(24'h000100, 24'h000100, 6'b000000));
        for (i = 0; i < 6; i++)
        begin
            send_voxel(make_voxel(24'h0, 24'h0, 6'b1 << i));
            send_voxel(make_voxel(24'hFFFFFF, 24'hFFFFFF, 6'b1 << i));
        end
        send_voxel(make_voxel(24'h000500, 24'h000500, 6'b111111));
        send_voxel(make_voxel(24'h0, 24'hFFFFFF, 6'b000011));
        send_voxel(make_voxel(24'h0, 24'hFFFFFF, 6'b111111));
        send_voxel(make_voxel(24'hFFFFFF, 24'hFFFFFF, 6'b111111));
        send_voxel(make_voxel(24'h001000, 24'h001080, 6'b010101));
    endtask

    task automatic test_weights;
        voxel_t v;
        // Only the x pair known, weight 2: a gap of 2^15 gives a zero discriminant.
        set_weights(16'd2, 16'd16384, 16'd11378);
        v = make_voxel(24'd1000, 24'd33768, 6'b000011);
        send_voxel(v);
        v.d[1] = 24'd33767;
        send_voxel(v);
        // All weights zero: degenerate quadratic.
        set_weights(16'd0, 16'd0, 16'd0);
        send_voxel(make_voxel(24'h000300, 24'h000400, 6'b111111));
        set_weights(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_voxel(make_voxel(24'hFFFFFF, 24'hFFFFFF, 6'b111111));
        send_voxel(make_voxel(24'h000200, 24'h000201, 6'b110011));
        // Out-of-range index leaves every weight untouched.
        write_weight(2'd3, 16'h1234);
        send_voxel(make_voxel(24'h000200, 24'h000280, 6'b101101));
    endtask

    task automatic test_random(int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            if (n % 150 == 149)
                set_weights(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)),
                            16'($urandom_range(0, 16'hFFFF)));
            if (n % 300 == 0)
            begin
                tx_quiet = 1'($urandom_range(0, 1));
                rx_quiet = 1'($urandom_range(0, 1));
            end
            send_voxel(rand_voxel());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    task automatic test_backpressure;
        int n;
        // Hold the output long enough to fill the pipeline and the skid register.
        tx_quiet = 1'b1;
        rx_hold = 300;
        for (n = 0; n < 150; n++)
            send_voxel(rand_voxel());
        tx_quiet = 1'b0;
        drain();
        for (n = 0; n < 20; n++)
            send_voxel(rand_voxel());
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = evu_pkg::CFG_WEIGHT_X;
        cfg_data = '0;
        {dist_x_minus, dist_x_plus, dist_y_minus, dist_y_plus, dist_z_minus, dist_z_plus} = '0;
        {known_x_minus, known_x_plus, known_y_minus, known_y_plus, known_z_minus,
         known_z_plus} = '0;
        wx = evu_pkg::WEIGHT_X_RESET;
        wy = evu_pkg::WEIGHT_Y_RESET;
        wz = evu_pkg::WEIGHT_Z_RESET;
        mismatches = 0;
        rx_wait = 0;
        rx_hold = 0;
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_weights();
        set_weights(evu_pkg::WEIGHT_X_RESET, evu_pkg::WEIGHT_Y_RESET, evu_pkg::WEIGHT_Z_RESET);
        test_random(450);
        test_backpressure();
        set_weights(16'd1, 16'd40000, 16'd8000);
        test_random(300);

        drain();
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
